>>> rtl/locc_pkg.sv
// Package for the lock-order cycle checker.
// Holds the command and mode codes and the sequencer state type.
// No dependencies.
`default_nettype none

package locc_pkg;

  localparam logic [1:0] CMD_CHECK   = 2'd0;
  localparam logic [1:0] CMD_ACQUIRE = 2'd1;
  localparam logic [1:0] CMD_RELEASE = 2'd2;

  localparam logic [1:0] MODE_OFF   = 2'd0;
  localparam logic [1:0] MODE_WARN  = 2'd1;
  localparam logic [1:0] MODE_PANIC = 2'd2;

  localparam int CNT_W = 32;
  localparam int OVF_W = 16;
  localparam int CLS_W = 6;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_CHK_ENTRY,
    ST_CHK_H,
    ST_CHK_ROW,
    ST_WALK_SCAN,
    ST_WALK_POP,
    ST_WALK_NODE,
    ST_REVERSAL,
    ST_EDGE_READ,
    ST_EDGE_WRITE,
    ST_ACQUIRE,
    ST_REL_REQ,
    ST_REL_CMP,
    ST_SHIFT_REQ,
    ST_SHIFT_WR,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

>>> rtl/lock_order_cycle_checker_unit.sv
// A command is ignored in off mode or when its code is not check, acquire or release.
// One command at a time; busy is high from the transfer until the result strobe has passed.
// The depth-first walk scans one order-matrix bit per cycle, which sets the check time.
// Synchronous active-high reset clears the result counters, held-lock depths and both matrix valid bits.
// Depends on locc_pkg.
`default_nettype none

module lock_order_cycle_checker_unit #(
  parameter int NUM_CLASSES = 64,
  parameter int HELD_DEPTH  = 12,
  parameter int NUM_CPUS    = 8,
  parameter int EDGE_LIMIT  = 512
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        mode_wr_en,
  input  wire logic [1:0]  mode_wr_data,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  command,
  input  wire logic [2:0]  cpu,
  input  wire logic [5:0]  lock_class,
  input  wire logic [31:0] lock_handle,
  output logic             done,
  output logic             reversal_found,
  output logic [5:0]       other_class,
  output logic             stop_requested,
  output logic [31:0]      reversal_total,
  output logic [3:0]       held_count,
  output logic [15:0]      untracked_count,
  output logic [9:0]       edges_learned
);

  localparam int CIW = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
  localparam int SPW = $clog2(NUM_CLASSES + 1);
  localparam int DW  = $clog2(HELD_DEPTH + 1);
  localparam int CPW = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
  localparam int HN  = NUM_CPUS * HELD_DEPTH;
  localparam int HAW = (HN > 1) ? $clog2(HN) : 1;
  localparam int EW  = $clog2(EDGE_LIMIT + 1);
  localparam int HEW = locc_pkg::CLS_W + locc_pkg::CNT_W;
  localparam logic [NUM_CLASSES-1:0] ROW_ONE = {{(NUM_CLASSES-1){1'b0}}, 1'b1};
  localparam logic [CIW-1:0] LAST_J = CIW'(NUM_CLASSES - 1);

  locc_pkg::state_t state, state_next;

  logic [1:0]                  mode;
  logic [1:0]                  cmd_q;
  logic [locc_pkg::CLS_W-1:0]  cls_q;
  logic [31:0]                 handle_q;
  logic [CPW-1:0]              cpu_q;
  logic [HAW-1:0]              base_q;
  logic [DW-1:0]               idx;
  logic [DW-1:0]               k;
  logic [locc_pkg::CLS_W-1:0]  hreg;
  logic [CIW-1:0]              node;
  logic [CIW-1:0]              jcnt;
  logic [SPW-1:0]              sp;
  logic [NUM_CLASSES-1:0]      visited;
  logic                        found_q;
  logic [locc_pkg::CLS_W-1:0]  other_q;
  logic [31:0]                 rev_cnt;
  logic [EW-1:0]               edge_cnt;
  logic [DW-1:0]               depth_arr [NUM_CPUS];
  logic [15:0]                 ovf_arr [NUM_CPUS];

  logic [NUM_CLASSES-1:0] order_mem [NUM_CLASSES];
  logic [NUM_CLASSES-1:0] order_vld;
  logic [NUM_CLASSES-1:0] order_rd;
  logic                   order_ok;
  logic                   order_we;
  logic [CIW-1:0]         order_wa, order_ra;
  logic [NUM_CLASSES-1:0] order_wd, order_row;

  logic [NUM_CLASSES-1:0] rep_mem [NUM_CLASSES];
  logic [NUM_CLASSES-1:0] rep_vld;
  logic [NUM_CLASSES-1:0] rep_rd;
  logic                   rep_ok;
  logic                   rep_we;
  logic [CIW-1:0]         rep_ra;
  logic [NUM_CLASSES-1:0] rep_wd, rep_row;

  logic [HEW-1:0] held_mem [HN];
  logic [HEW-1:0] held_rd, held_wd;
  logic           held_we;
  logic [HAW-1:0] held_wa, held_ra;

  logic [CIW-1:0] stk_mem [NUM_CLASSES];
  logic [CIW-1:0] stk_rd;
  logic           stk_we;
  logic [CIW-1:0] stk_wa, stk_ra;

  logic [CPW-1:0]         cpu_eff;
  logic [CIW-1:0]         cls_i, h_i;
  logic [locc_pkg::CLS_W-1:0] held_rd_cls;
  logic [DW-1:0]          depth_cur;
  logic                   cls_ok, h_skip, scan_new, scan_hit, scan_push;
  logic [SPW-1:0]         sp_new;

  assign cpu_eff     = (32'(cpu) < NUM_CPUS) ? CPW'(cpu) : '0;
  assign cls_i       = CIW'(cls_q);
  assign h_i         = CIW'(hreg);
  assign held_rd_cls = held_rd[HEW-1:locc_pkg::CNT_W];
  assign depth_cur   = depth_arr[cpu_q];
  assign cls_ok      = 32'(cls_q) < NUM_CLASSES;
  assign h_skip      = (32'(held_rd_cls) >= NUM_CLASSES) || (held_rd_cls == cls_q);
  assign order_row   = order_ok ? order_rd : '0;
  assign rep_row     = rep_ok ? rep_rd : '0;
  assign scan_new    = order_row[jcnt] && !visited[jcnt];
  assign scan_hit    = scan_new && (jcnt == h_i);
  assign scan_push   = scan_new && !scan_hit && (32'(sp) < NUM_CLASSES);
  assign sp_new      = scan_push ? sp + 1'b1 : sp;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= locc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    order_we   = 1'b0;
    order_wa   = h_i;
    order_wd   = order_row | (ROW_ONE << cls_i);
    order_ra   = node;
    rep_we     = 1'b0;
    rep_ra     = h_i;
    rep_wd     = rep_row | (ROW_ONE << cls_i);
    held_we    = 1'b0;
    held_wa    = base_q + HAW'(depth_cur);
    held_wd    = {cls_q, handle_q};
    held_ra    = base_q + HAW'(idx);
    stk_we     = 1'b0;
    stk_wa     = CIW'(sp);
    stk_ra     = CIW'(sp);
    unique case (state)
      locc_pkg::ST_IDLE: begin
        if (start) begin
          if (mode == locc_pkg::MODE_OFF) begin
            state_next = locc_pkg::ST_DONE;
          end else begin
            unique case (command)
              locc_pkg::CMD_CHECK:   state_next = locc_pkg::ST_CHK_ENTRY;
              locc_pkg::CMD_ACQUIRE: state_next = locc_pkg::ST_ACQUIRE;
              locc_pkg::CMD_RELEASE: state_next = locc_pkg::ST_REL_REQ;
              default:               state_next = locc_pkg::ST_DONE;
            endcase
          end
        end
      end
      locc_pkg::ST_CHK_ENTRY: begin
        if (!cls_ok || idx == depth_cur) begin
          state_next = locc_pkg::ST_DONE;
        end else begin
          state_next = locc_pkg::ST_CHK_H;
        end
      end
      locc_pkg::ST_CHK_H: begin
        order_ra = CIW'(held_rd_cls);
        rep_ra   = CIW'(held_rd_cls);
        state_next = h_skip ? locc_pkg::ST_CHK_ENTRY : locc_pkg::ST_CHK_ROW;
      end
      locc_pkg::ST_CHK_ROW: begin
        order_ra = cls_i;
        state_next = order_row[cls_i] ? locc_pkg::ST_CHK_ENTRY : locc_pkg::ST_WALK_SCAN;
      end
      locc_pkg::ST_WALK_SCAN: begin
        stk_we = scan_push;
        if (scan_hit) begin
          state_next = locc_pkg::ST_REVERSAL;
        end else if (jcnt == LAST_J) begin
          state_next = (sp_new == '0) ? locc_pkg::ST_EDGE_READ : locc_pkg::ST_WALK_POP;
        end
      end
      locc_pkg::ST_WALK_POP: begin
        state_next = locc_pkg::ST_WALK_NODE;
      end
      locc_pkg::ST_WALK_NODE: begin
        order_ra   = stk_rd;
        state_next = locc_pkg::ST_WALK_SCAN;
      end
      locc_pkg::ST_REVERSAL: begin
        rep_we     = !rep_row[cls_i];
        state_next = locc_pkg::ST_CHK_ENTRY;
      end
      locc_pkg::ST_EDGE_READ: begin
        order_ra   = h_i;
        state_next = locc_pkg::ST_EDGE_WRITE;
      end
      locc_pkg::ST_EDGE_WRITE: begin
        order_we   = 1'b1;
        state_next = locc_pkg::ST_CHK_ENTRY;
      end
      locc_pkg::ST_ACQUIRE: begin
        held_we    = 32'(depth_cur) < HELD_DEPTH;
        state_next = locc_pkg::ST_DONE;
      end
      locc_pkg::ST_REL_REQ: begin
        held_ra    = base_q + HAW'(idx - 1'b1);
        state_next = (idx == '0) ? locc_pkg::ST_DONE : locc_pkg::ST_REL_CMP;
      end
      locc_pkg::ST_REL_CMP: begin
        state_next = (held_rd[locc_pkg::CNT_W-1:0] == handle_q) ? locc_pkg::ST_SHIFT_REQ
                                                                : locc_pkg::ST_REL_REQ;
      end
      locc_pkg::ST_SHIFT_REQ: begin
        held_ra = base_q + HAW'(k + 1'b1);
        state_next = ((32'(k) + 1) >= 32'(depth_cur)) ? locc_pkg::ST_DONE
                                                      : locc_pkg::ST_SHIFT_WR;
      end
      locc_pkg::ST_SHIFT_WR: begin
        held_we    = 1'b1;
        held_wa    = base_q + HAW'(k);
        held_wd    = held_rd;
        state_next = locc_pkg::ST_SHIFT_REQ;
      end
      locc_pkg::ST_DONE: begin
        state_next = locc_pkg::ST_IDLE;
      end
      default: begin
        state_next = locc_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (order_we) begin
      order_mem[order_wa] <= order_wd;
    end
    order_rd <= order_mem[order_ra];
    order_ok <= order_vld[order_ra];
    if (rep_we) begin
      rep_mem[h_i] <= rep_wd;
    end
    rep_rd <= rep_mem[rep_ra];
    rep_ok <= rep_vld[rep_ra];
    if (held_we) begin
      held_mem[held_wa] <= held_wd;
    end
    held_rd <= held_mem[held_ra];
    if (stk_we) begin
      stk_mem[stk_wa] <= jcnt;
    end
    stk_rd <= stk_mem[stk_ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      order_vld <= '0;
      rep_vld   <= '0;
    end else begin
      if (order_we) begin
        order_vld[order_wa] <= 1'b1;
      end
      if (rep_we) begin
        rep_vld[h_i] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == locc_pkg::ST_IDLE && start) begin
      cmd_q    <= command;
      cls_q    <= lock_class;
      handle_q <= lock_handle;
      cpu_q    <= cpu_eff;
      base_q   <= HAW'(32'(cpu_eff) * HELD_DEPTH);
      idx      <= (command == locc_pkg::CMD_RELEASE) ? depth_arr[cpu_eff] : '0;
    end
    unique case (state)
      locc_pkg::ST_CHK_H: begin
        hreg <= held_rd_cls;
        if (h_skip) begin
          idx <= idx + 1'b1;
        end
      end
      locc_pkg::ST_CHK_ROW: begin
        node    <= cls_i;
        visited <= ROW_ONE << cls_i;
        sp      <= '0;
        jcnt    <= '0;
        if (order_row[cls_i]) begin
          idx <= idx + 1'b1;
        end
      end
      locc_pkg::ST_WALK_SCAN: begin
        jcnt <= jcnt + 1'b1;
        if (scan_new && !scan_hit) begin
          visited[jcnt] <= 1'b1;
        end
        sp <= (jcnt == LAST_J && sp_new != '0) ? sp_new - 1'b1 : sp_new;
      end
      locc_pkg::ST_WALK_NODE: begin
        node <= stk_rd;
        jcnt <= '0;
      end
      locc_pkg::ST_REVERSAL,
      locc_pkg::ST_EDGE_WRITE: begin
        idx <= idx + 1'b1;
      end
      locc_pkg::ST_REL_CMP: begin
        if (held_rd[locc_pkg::CNT_W-1:0] == handle_q) begin
          k <= idx - 1'b1;
        end else begin
          idx <= idx - 1'b1;
        end
      end
      locc_pkg::ST_SHIFT_WR: begin
        k <= k + 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode     <= locc_pkg::MODE_WARN;
      found_q  <= 1'b0;
      other_q  <= '0;
      rev_cnt  <= '0;
      edge_cnt <= '0;
      for (int c = 0; c < NUM_CPUS; c++) begin
        depth_arr[c] <= '0;
        ovf_arr[c]   <= '0;
      end
    end else begin
      if (mode_wr_en) begin
        mode <= mode_wr_data;
      end
      if (state == locc_pkg::ST_IDLE && start) begin
        found_q <= 1'b0;
        other_q <= '0;
      end
      if (state == locc_pkg::ST_REVERSAL && !rep_row[cls_i]) begin
        found_q <= 1'b1;
        other_q <= hreg;
        if (rev_cnt != '1) begin
          rev_cnt <= rev_cnt + 1'b1;
        end
      end
      if (state == locc_pkg::ST_EDGE_WRITE && 32'(edge_cnt) < EDGE_LIMIT) begin
        edge_cnt <= edge_cnt + 1'b1;
      end
      if (state == locc_pkg::ST_ACQUIRE) begin
        if (32'(depth_cur) < HELD_DEPTH) begin
          depth_arr[cpu_q] <= depth_cur + 1'b1;
        end else if (ovf_arr[cpu_q] != '1) begin
          ovf_arr[cpu_q] <= ovf_arr[cpu_q] + 1'b1;
        end
      end
      if (state == locc_pkg::ST_REL_REQ && idx == '0 && ovf_arr[cpu_q] != '0) begin
        ovf_arr[cpu_q] <= ovf_arr[cpu_q] - 1'b1;
      end
      if (state == locc_pkg::ST_SHIFT_REQ && (32'(k) + 1) >= 32'(depth_cur)) begin
        depth_arr[cpu_q] <= depth_cur - 1'b1;
      end
    end
  end

  assign busy            = state != locc_pkg::ST_IDLE;
  assign done            = state == locc_pkg::ST_DONE;
  assign reversal_found  = found_q;
  assign other_class     = other_q;
  assign stop_requested  = found_q && (mode == locc_pkg::MODE_PANIC) &&
                           (cmd_q == locc_pkg::CMD_CHECK);
  assign reversal_total  = rev_cnt;
  assign held_count      = 4'(depth_cur);
  assign untracked_count = ovf_arr[cpu_q];
  assign edges_learned   = 10'(edge_cnt);

endmodule

`default_nettype wire

>>> rtl/locc_checker.sv
// Port-level checks for the lock-order cycle checker.
// Observes the top level's handshake and result ports; bound to lock_order_cycle_checker_unit.
`default_nettype none

module locc_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       start,
  input wire logic       busy,
  input wire logic       done,
  input wire logic       reversal_found,
  input wire logic [5:0] other_class,
  input wire logic       stop_requested
);

  a_done_single: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("Result strobe lasted more than one cycle.");

  a_busy_after_transfer: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("Block not busy after an input transfer.");

  a_done_while_busy: assert property (@(posedge clk) disable iff (rst) done |-> busy)
    else $error("Result strobe without busy.");

  a_stop_needs_found: assert property (@(posedge clk) disable iff (rst)
    (done && stop_requested) |-> reversal_found)
    else $error("Stop requested without a reversal.");

  a_other_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !reversal_found) |-> (other_class == 6'd0))
    else $error("Other class set without a reversal.");

endmodule

bind lock_order_cycle_checker_unit locc_checker u_locc_checker (
  .clk(clk),
  .rst(rst),
  .start(start),
  .busy(busy),
  .done(done),
  .reversal_found(reversal_found),
  .other_class(other_class),
  .stop_requested(stop_requested)
);

`default_nettype wire

>>> dv/tb_top.sv
// Testbench for the lock-order cycle checker unit.
// Drives command transfers from a queue and checks each result strobe against
// an internal order-graph predictor. Depends on locc_pkg and the unit RTL.
`timescale 1ns / 100ps
`default_nettype none

module tb_top;

  localparam logic [1:0] MODE_ALT = 2'd3;
  localparam logic [1:0] CMD_NONE = 2'd3;
  localparam int CYCLE_LIMIT = 120000000;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [2:0]  cpu;
    logic [5:0]  cls;
    logic [31:0] handle;
  } lock_cmd_t;

  typedef struct packed {
    logic        found;
    logic [5:0]  other;
    logic        stop;
    logic [31:0] rev_total;
    logic [3:0]  depth;
    logic [15:0] untracked;
    logic [9:0]  edges;
  } lock_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic mode_wr_en = 1'b0;
  logic [1:0] mode_wr_data = '0;
  logic start = 1'b0;
  logic [1:0] command = '0;
  logic [2:0] cpu = '0;
  logic [5:0] lock_class = '0;
  logic [31:0] lock_handle = '0;
  logic busy, done, reversal_found, stop_requested;
  logic [5:0] other_class;
  logic [31:0] reversal_total;
  logic [3:0] held_count;
  logic [15:0] untracked_count;
  logic [9:0] edges_learned;

  lock_order_cycle_checker_unit u_top (
    .clk(clk), .rst(rst), .mode_wr_en(mode_wr_en), .mode_wr_data(mode_wr_data),
    .start(start), .busy(busy), .command(command), .cpu(cpu),
    .lock_class(lock_class), .lock_handle(lock_handle), .done(done),
    .reversal_found(reversal_found), .other_class(other_class),
    .stop_requested(stop_requested), .reversal_total(reversal_total),
    .held_count(held_count), .untracked_count(untracked_count),
    .edges_learned(edges_learned)
  );

  always #10 clk = ~clk;

  // Predictor state.
  logic [1:0]  cur_mode = locc_pkg::MODE_WARN;
  logic [63:0] order_m [64];
  logic [63:0] reported_m [64];
  logic [31:0] held_h [8][12];
  logic [5:0]  held_c [8][12];
  int          depth_of [8];
  int          ovf_of [8];
  logic [31:0] rev_cnt;
  int          edge_cnt;

  lock_cmd_t pending_q [$];
  lock_res_t expected_q [$];
  lock_cmd_t cur_cmd;
  int gap_left = 0;
  bit idle_on = 1'b1;
  int fails = 0;
  int cycles = 0;

  // Stimulus-side view of the handles each cpu holds.
  logic [31:0] gen_held [8][$];

  initial begin
    for (int i = 0; i < 64; i++) begin
      order_m[i] = '0;
      reported_m[i] = '0;
    end
    for (int c = 0; c < 8; c++) begin
      depth_of[c] = 0;
      ovf_of[c] = 0;
    end
    rev_cnt = '0;
    edge_cnt = 0;
  end

  function automatic bit reachable(int src, int dst);
    logic [63:0] seen;
    int stk[$];
    int n;
    seen = '0;
    seen[src] = 1'b1;
    stk.push_back(src);
    while (stk.size() > 0) begin
      n = stk.pop_back();
      for (int j = 0; j < 64; j++) begin
        if (order_m[n][j] && !seen[j]) begin
          if (j == dst) return 1'b1;
          seen[j] = 1'b1;
          stk.push_back(j);
        end
      end
    end
    return 1'b0;
  endfunction

  function automatic lock_res_t lock_order_predict(lock_cmd_t c);
    lock_res_t r;
    int p, d, h;
    bit hit;
    r = '0;
    p = c.cpu;
    d = depth_of[p];
    if (cur_mode != locc_pkg::MODE_OFF) begin
      if (c.cmd == locc_pkg::CMD_CHECK) begin
        for (int i = 0; i < d; i++) begin
          h = held_c[p][i];
          if (h == c.cls || order_m[h][c.cls]) continue;
          if (reachable(c.cls, h)) begin
            if (!reported_m[h][c.cls]) begin
              reported_m[h][c.cls] = 1'b1;
              if (rev_cnt != 32'hFFFF_FFFF) rev_cnt++;
              r.found = 1'b1;
              r.other = h[5:0];
            end
          end else begin
            order_m[h][c.cls] = 1'b1;
            if (edge_cnt < 512) edge_cnt++;
          end
        end
        r.stop = r.found && cur_mode == locc_pkg::MODE_PANIC;
      end else if (c.cmd == locc_pkg::CMD_ACQUIRE) begin
        if (d >= 12) begin
          if (ovf_of[p] < 16'hFFFF) ovf_of[p]++;
        end else begin
          held_h[p][d] = c.handle;
          held_c[p][d] = c.cls;
          depth_of[p] = d + 1;
        end
      end else if (c.cmd == locc_pkg::CMD_RELEASE) begin
        hit = 1'b0;
        for (int i = d; i > 0 && !hit; i--) begin
          if (held_h[p][i-1] == c.handle) begin
            for (int k = i - 1; k + 1 < d; k++) begin
              held_h[p][k] = held_h[p][k+1];
              held_c[p][k] = held_c[p][k+1];
            end
            depth_of[p] = d - 1;
            hit = 1'b1;
          end
        end
        if (!hit && ovf_of[p] > 0) ovf_of[p]--;
      end
    end
    r.rev_total = rev_cnt;
    r.depth = depth_of[p][3:0];
    r.untracked = ovf_of[p][15:0];
    r.edges = edge_cnt[9:0];
    return r;
  endfunction

  // Driver: one command per transfer, start held across back-to-back items.
  always @(posedge clk) begin
    bit xfer;
    xfer = start && !busy;
    if (xfer) expected_q.push_back(lock_order_predict(cur_cmd));
    if (!rst && (!start || xfer)) begin
      if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (pending_q.size() > 0) begin
        cur_cmd = pending_q.pop_front();
        command <= cur_cmd.cmd;
        cpu <= cur_cmd.cpu;
        lock_class <= cur_cmd.cls;
        lock_handle <= cur_cmd.handle;
        start <= 1'b1;
        if (idle_on && $urandom_range(0, 3) == 0) gap_left = $urandom_range(1, 10);
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: compare each result strobe with the oldest expectation.
  always @(posedge clk) begin
    lock_res_t e;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
    if (!rst && done) begin
      if (expected_q.size() == 0) begin
        $error("result transfer with no expectation pending");
        fails++;
      end else begin
        e = expected_q.pop_front();
        if (reversal_found !== e.found) begin
          $error("reversal_found exp %0d got %0d", e.found, reversal_found); fails++;
        end
        if (other_class !== e.other) begin
          $error("other_class exp %0d got %0d", e.other, other_class); fails++;
        end
        if (stop_requested !== e.stop) begin
          $error("stop_requested exp %0d got %0d", e.stop, stop_requested); fails++;
        end
        if (reversal_total !== e.rev_total) begin
          $error("reversal_total exp %0d got %0d", e.rev_total, reversal_total); fails++;
        end
        if (held_count !== e.depth) begin
          $error("held_count exp %0d got %0d", e.depth, held_count); fails++;
        end
        if (untracked_count !== e.untracked) begin
          $error("untracked_count exp %0d got %0d", e.untracked, untracked_count); fails++;
        end
        if (edges_learned !== e.edges) begin
          $error("edges_learned exp %0d got %0d", e.edges, edges_learned); fails++;
        end
      end
    end
  end

  function automatic void add_cmd(logic [1:0] c, int p, int cl, logic [31:0] hd);
    lock_cmd_t t;
    t.cmd = c;
    t.cpu = p[2:0];
    t.cls = cl[5:0];
    t.handle = hd;
    pending_q.push_back(t);
    if (c == locc_pkg::CMD_ACQUIRE && gen_held[p].size() < 14) gen_held[p].push_back(hd);
  endfunction

  // Well-formed traffic: check then acquire, release of a held lock, some noise.
  function automatic void add_random(int n);
    int p, cl, k;
    for (int i = 0; i < n; i++) begin
      p = $urandom_range(0, 7);
      cl = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 11);
      k = $urandom_range(0, 19);
      if (k < 10 && gen_held[p].size() < 13) begin
        add_cmd(locc_pkg::CMD_CHECK, p, cl, $urandom);
        add_cmd(locc_pkg::CMD_ACQUIRE, p, cl, $urandom);
        i++;
      end else if (k < 17 && gen_held[p].size() > 0) begin
        k = $urandom_range(0, gen_held[p].size() - 1);
        add_cmd(locc_pkg::CMD_RELEASE, p, cl, gen_held[p][k]);
        gen_held[p].delete(k);
      end else begin
        add_cmd(logic'(k[0]) ? CMD_NONE : 2'($urandom_range(0, 2)), p, cl, $urandom);
      end
    end
  endfunction

  task automatic write_mode(logic [1:0] m);
    @(posedge clk);
    mode_wr_en <= 1'b1;
    mode_wr_data <= m;
    cur_mode = m;
    @(posedge clk);
    mode_wr_en <= 1'b0;
  endtask

  task automatic drain();
    do @(negedge clk);
    while (pending_q.size() > 0 || start || expected_q.size() > 0);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    write_mode(locc_pkg::MODE_PANIC);
    add_cmd(locc_pkg::CMD_ACQUIRE, 0, 0, 32'h0000_0000);
    add_cmd(locc_pkg::CMD_ACQUIRE, 0, 63, 32'hFFFF_FFFF);
    add_cmd(locc_pkg::CMD_CHECK, 0, 5, 32'h1234_5678);
    add_cmd(locc_pkg::CMD_CHECK, 0, 0, 32'h0);
    add_cmd(locc_pkg::CMD_ACQUIRE, 1, 5, 32'hA5A5_A5A5);
    add_cmd(locc_pkg::CMD_CHECK, 1, 0, 32'h5A5A_5A5A);
    add_cmd(locc_pkg::CMD_CHECK, 1, 0, 32'h5A5A_5A5A);
    add_cmd(locc_pkg::CMD_CHECK, 1, 63, 32'h0);
    add_cmd(locc_pkg::CMD_RELEASE, 0, 0, 32'hFFFF_FFFF);
    add_cmd(locc_pkg::CMD_RELEASE, 0, 0, 32'hDEAD_BEEF);
    add_cmd(CMD_NONE, 1, 5, 32'h0);
    for (int i = 0; i < 13; i++) add_cmd(locc_pkg::CMD_ACQUIRE, 7, i, 32'h100 + i);
    add_cmd(locc_pkg::CMD_RELEASE, 7, 0, 32'h0BAD_0BAD);
    add_cmd(locc_pkg::CMD_RELEASE, 7, 0, 32'h105);
    drain();
    write_mode(locc_pkg::MODE_OFF);
    add_random(20);
    drain();
    write_mode(MODE_ALT);
    add_random(100);
    drain();
    write_mode(locc_pkg::MODE_WARN);
    add_random(150);
    drain();
    write_mode(locc_pkg::MODE_PANIC);
    add_random(100);
    drain();
    idle_on = 1'b0;
    write_mode(locc_pkg::MODE_WARN);
    add_random(60);
    drain();
    repeat (10) @(posedge clk);
    if (fails == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

`default_nettype wire
